@@ hw/rtl/chsw_pkg.sv @@
// Shared types, constants and the Chebyshev coefficient table of the waveshaper.
// Depends on nothing; used by chebyshev_sum_waveshaper_core.
package chsw_pkg;

	// Highest Chebyshev term held in the weight store.
	localparam int MAX_ORDER = 15;
	localparam int NTERMS    = MAX_ORDER + 1;
	localparam int IDX_W     = (NTERMS > 1) ? $clog2(NTERMS) : 1;

	// Field widths.
	localparam int ORDER_W  = 4;
	localparam int WIDX_W   = 4;
	localparam int WEIGHT_W = 18;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 32;
	localparam int FRAC     = 15;

	// Power-form coefficients are kept modulo 2^48.
	localparam int COEF_W = 48;

	// Width of one integer coefficient of T0..T15; the largest magnitude is 92160.
	localparam int CH_W = 18;

	// Horner accumulator and its split into two halves for the shared multiplier.
	localparam int ACC_W   = 56;
	localparam int LO_W    = 28;
	localparam int MUL_A_W = LO_W + 1;
	localparam int MUL_B_W = CH_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	typedef logic [NTERMS-1:0][NTERMS-1:0][CH_W-1:0] ch_tab_t;

	// Command carried by an input item.
	typedef enum logic {
		CMD_SHAPE  = 1'b0,
		CMD_WEIGHT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REBUILD,
		ST_HORNER_LO,
		ST_HORNER_HI,
		ST_DONE
	} state_t;

	// Power-form coefficients of the Chebyshev polynomials, row k holding T_k.
	function automatic ch_tab_t build_ch_tab();
		logic [NTERMS-1:0][COEF_W-1:0] prev;
		logic [NTERMS-1:0][COEF_W-1:0] cur;
		logic [NTERMS-1:0][COEF_W-1:0] nxt;
		ch_tab_t tab;
		tab  = '0;
		prev = '0;
		cur  = '0;
		nxt  = '0;
		cur[0] = COEF_W'(1);
		for (int k = 0; k < NTERMS; k++) begin
			if (k == 1) begin
				prev   = cur;
				cur    = '0;
				cur[1] = COEF_W'(1);
			end else if (k >= 2) begin
				nxt[0] = COEF_W'(0) - prev[0];
				for (int j = 1; j < NTERMS; j++) begin
					nxt[j] = (cur[j-1] << 1) - prev[j];
				end
				prev = cur;
				cur  = nxt;
			end
			for (int j = 0; j < NTERMS; j++) begin
				tab[k][j] = cur[j][CH_W-1:0];
			end
		end
		return tab;
	endfunction

	localparam ch_tab_t CH_TAB = build_ch_tab();

endpackage

@@ hw/rtl/chebyshev_sum_waveshaper_core.sv @@
// Chebyshev-sum waveshaper: weight store, coefficient rebuild and Horner evaluation.
// Depends on chsw_pkg for widths, the state type and the Chebyshev table.
//
// Usage. The input channel (in_valid, in_stall) carries one item per handshake:
// command 0 shapes the item's sample, command 1 stores weight_value as the weight
// of term weight_index. An item is taken at a rising edge with in_valid high and
// in_stall low. The output channel (out_valid, out_stall) returns one item per
// shaped sample; weight writes return nothing. The configuration channel
// (cfg_valid, cfg_ready, cfg_data) writes the order register and is taken only
// while the block is idle.
// Sequencing. One shared 29 x 18 multiplier does all the arithmetic under a small
// sequencer. A sample takes two multiplier passes per Horner step, since the
// accumulator is split into halves, and then loads the output register; the block
// takes no new item until that sample is finished and its result is loaded.
// A weight write or an order write rebuilds the power-form table with one
// multiply-accumulate per table term. The block stalls its input throughout.
// Reset clears the weights, the coefficient table and the order at once, so the
// block shapes every sample to zero until weights are written.
// The result sits in an output register. When the receiver stalls, the block
// still takes the next item; a finished result waits until that register frees.
module chebyshev_sum_waveshaper_core
	import chsw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [WIDX_W-1:0]          weight_index,
	input  logic signed [WEIGHT_W-1:0] weight_value,
	input  logic signed [SAMPLE_W-1:0] sample,

	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_W-1:0]    shaped_sample,
	output logic                       saturated,

	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ORDER_W-1:0]         cfg_data
);

	state_t state_q;
	state_t state_next;

	logic [ORDER_W-1:0]                    order_q;
	logic [NTERMS-1:0][WEIGHT_W-1:0]       weight_q;
	logic [NTERMS-1:0][COEF_W-1:0]         coef_q;

	logic [IDX_W-1:0]                      j_q;
	logic [IDX_W-1:0]                      k_q;
	logic [IDX_W-1:0]                      i_q;
	logic [COEF_W-1:0]                     sum_q;
	logic signed [ACC_W-1:0]               acc_q;
	logic signed [PROD_W-1:0]              prod_q;
	logic signed [SAMPLE_W-1:0]            sample_q;
	logic                                  out_valid_q;
	logic signed [OUT_W-1:0]               shaped_q;
	logic                                  saturated_q;

	logic [IDX_W-1:0]                      top;
	logic                                  widx_ok;
	logic                                  cfg_take;
	logic                                  in_take;
	logic                                  out_free;
	logic                                  load_out;
	logic [IDX_W-1:0]                      coef_raddr;
	logic signed [ACC_W-1:0]               coef_ext;
	logic signed [MUL_A_W-1:0]             mul_a;
	logic signed [MUL_B_W-1:0]             mul_b;
	logic signed [PROD_W-1:0]              mul_p;
	logic [COEF_W-1:0]                     sum_next;
	logic signed [ACC_W-1:0]               acc_next;
	logic                                  rb_last_k;
	logic                                  sat_flag;
	logic signed [OUT_W-1:0]               sat_value;

	// Orders above the store's depth fall back to the highest stored term.
	assign top = (32'(order_q) > MAX_ORDER) ? IDX_W'(MAX_ORDER) : IDX_W'(order_q);
	assign widx_ok   = (32'(weight_index) <= MAX_ORDER);
	assign rb_last_k = (k_q == top);
	assign out_free  = !out_valid_q || !out_stall;

	// The one coefficient read port: the top term when a sample starts, then the
	// next lower term on the second pass of each Horner step.
	assign coef_ext = ACC_W'($signed(coef_q[coef_raddr]));

	// The shared multiplier.
	assign mul_p = mul_a * mul_b;

	// Rebuild: coefficient j gathers weight k times the x^j coefficient of T_k.
	assign sum_next = sum_q + COEF_W'(mul_p);

	// Horner step: floor(acc * x / 2^15) = hi * x * 2^(LO_W-15) + floor(lo * x / 2^15),
	// with the low-half product taken on the pass before.
	assign acc_next = (ACC_W'(mul_p) <<< (LO_W - FRAC))
	                + ACC_W'(prod_q >>> FRAC)
	                + coef_ext;

	// Clip when the accumulator's bits from bit 31 upward are not all copies of the sign.
	assign sat_flag  = !((&acc_q[ACC_W-1:OUT_W-1]) || !(|acc_q[ACC_W-1:OUT_W-1]));
	assign sat_value = acc_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
	                                  : {1'b0, {(OUT_W-1){1'b1}}};

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					state_next = ST_REBUILD;
				end else if (in_valid) begin
					if (command == CMD_WEIGHT) begin
						state_next = widx_ok ? ST_REBUILD : ST_IDLE;
					end else begin
						state_next = (top == '0) ? ST_DONE : ST_HORNER_LO;
					end
				end
			end
			ST_REBUILD: begin
				if (rb_last_k && (j_q == top)) begin
					state_next = ST_IDLE;
				end
			end
			ST_HORNER_LO: begin
				state_next = ST_HORNER_HI;
			end
			ST_HORNER_HI: begin
				state_next = (i_q == IDX_W'(1)) ? ST_DONE : ST_HORNER_LO;
			end
			ST_DONE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Handshakes and multiplier operand selection.
	always_comb begin
		cfg_ready  = 1'b0;
		in_stall   = 1'b1;
		load_out   = 1'b0;
		coef_raddr = top;
		mul_a      = MUL_A_W'($signed(weight_q[k_q]));
		mul_b      = $signed(CH_TAB[k_q][j_q]);
		case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_stall  = cfg_valid;
			end
			ST_REBUILD: begin
			end
			ST_HORNER_LO: begin
				mul_a = $signed({1'b0, acc_q[LO_W-1:0]});
				mul_b = MUL_B_W'(sample_q);
			end
			ST_HORNER_HI: begin
				mul_a      = MUL_A_W'($signed(acc_q[ACC_W-1:LO_W]));
				mul_b      = MUL_B_W'(sample_q);
				coef_raddr = i_q - IDX_W'(1);
			end
			ST_DONE: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	assign cfg_take = cfg_valid && cfg_ready;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			order_q     <= '0;
			weight_q    <= '0;
			coef_q      <= '0;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
		end else begin
			state_q <= state_next;

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_take) begin
				order_q <= cfg_data;
				j_q     <= '0;
				k_q     <= '0;
			end else if (in_take) begin
				if (command == CMD_WEIGHT) begin
					if (widx_ok) begin
						weight_q[IDX_W'(weight_index)] <= weight_value;
					end
					j_q <= '0;
					k_q <= '0;
				end else begin
					i_q <= top;
				end
			end

			if (state_q == ST_REBUILD) begin
				if (rb_last_k) begin
					coef_q[j_q] <= sum_next;
					k_q         <= '0;
					j_q         <= j_q + IDX_W'(1);
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end

			if (state_q == ST_HORNER_HI) begin
				i_q <= i_q - IDX_W'(1);
			end
		end
	end

	// Datapath registers; these need no reset.
	always_ff @(posedge clk) begin
		if (cfg_take || (in_take && (command == CMD_WEIGHT))) begin
			sum_q <= '0;
		end else if (state_q == ST_REBUILD) begin
			sum_q <= rb_last_k ? '0 : sum_next;
		end

		if (in_take && (command == CMD_SHAPE)) begin
			sample_q <= sample;
			acc_q    <= coef_ext;
		end else if (state_q == ST_HORNER_HI) begin
			acc_q <= acc_next;
		end

		if (state_q == ST_HORNER_LO) begin
			prod_q <= mul_p;
		end

		if (load_out) begin
			shaped_q    <= sat_flag ? sat_value : acc_q[OUT_W-1:0];
			saturated_q <= sat_flag;
		end
	end

	assign out_valid     = out_valid_q;
	assign shaped_sample = shaped_q;
	assign saturated     = saturated_q;

endmodule
